// ===== rtl/core/differential_drive_servo_mixer_unit_macros.svh =====
// Assertion macros shared by the mixer checker.
`ifndef DIFFERENTIAL_DRIVE_SERVO_MIXER_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_SERVO_MIXER_UNIT_MACROS_SVH

// Check on every edge, reset included.
`define DDSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

// Check only while out of reset.
`define DDSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`endif

// ===== rtl/core/ddsm_pkg.sv =====
// Types, codes and constants shared by the differential drive mixer.
package ddsm_pkg;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_TURN_DELTA    = 3'd0;
    localparam cfg_idx_t CFG_SPEED_DELTA   = 3'd1;
    localparam cfg_idx_t CFG_LEFT_LIMIT    = 3'd2;
    localparam cfg_idx_t CFG_RIGHT_LIMIT   = 3'd3;
    localparam cfg_idx_t CFG_SPEED_FLOOR   = 3'd4;
    localparam cfg_idx_t CFG_SPEED_CEILING = 3'd5;

    localparam logic [3:0] OP_FORWARD    = 4'd0;
    localparam logic [3:0] OP_REVERSE    = 4'd1;
    localparam logic [3:0] OP_STOP       = 4'd2;
    localparam logic [3:0] OP_TURN_LEFT  = 4'd3;
    localparam logic [3:0] OP_TURN_RIGHT = 4'd4;
    localparam logic [3:0] OP_SET_DIR    = 4'd5;
    localparam logic [3:0] OP_SPEED_UP   = 4'd6;
    localparam logic [3:0] OP_SLOW_DOWN  = 4'd7;
    localparam logic [3:0] OP_SET_SPEED  = 4'd8;
    localparam logic [3:0] OP_BUMP       = 4'd9;

    localparam logic signed [7:0] FULL_POS = 8'sd100;
    localparam logic signed [7:0] FULL_NEG = -8'sd100;

    // x/100 for x <= 10000 as (x * 5243) >> 19
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    // floor(x*180/200) for x <= 200 as (x * 9 * 6554) >> 16
    localparam logic [15:0] ANGLE_MUL    = 16'd58986;
    localparam int          ANGLE_SHIFT  = 16;

    // Step sizes and already saturated limits.
    typedef struct packed {
        logic [6:0]        turn_delta;
        logic [6:0]        speed_delta;
        logic signed [7:0] dir_lo;
        logic signed [7:0] dir_hi;
        logic signed [7:0] spd_lo;
        logic signed [7:0] spd_hi;
    } limits_t;

    // Speed and heading snapshot handed to the mixer.
    typedef struct packed {
        logic signed [7:0] speed;
        logic signed [7:0] heading;
    } drive_t;

    function automatic logic signed [7:0] trunc_div100(input logic signed [15:0] p);
        logic [14:0] mag;
        logic [27:0] scaled;
        logic [7:0]  q;
        mag    = p[15] ? 15'(-p) : p[14:0];
        scaled = 28'(mag) * 28'(DIV100_MUL);
        q      = scaled[DIV100_SHIFT +: 8];
        return p[15] ? -q : q;
    endfunction

    function automatic logic [7:0] servo_angle(input logic [7:0] x);
        logic [23:0] scaled;
        scaled = 24'(x) * 24'(ANGLE_MUL);
        return scaled[ANGLE_SHIFT +: 8];
    endfunction

endpackage

// ===== rtl/core/differential_drive_servo_mixer_unit.sv =====
// Top level of the differential drive servo mixer.
//
// s_ channel: one drive command per transaction,
//   tdata[3:0] opcode, [11:4] value, [19:12] bump_mask, [23:20] zero.
// m_ channel: one wheel result per transaction, tdata[7:0] left_angle,
//   [15:8] right_angle, [23:16] left_speed, [31:24] right_speed.
// cfg_ channel: writes the step and limit registers and never stalls;
//   write configuration only while no command is in flight.
// Throughput is one command per cycle while m_tready does not stall the output.
//   m_tvalid rises once the result has passed the command register, which loads
//   at the accepting edge, then the wheel products, divide by 100 and angle register.
// Commands that produce no result (bumped, bad direction, unused opcode)
//   drop before the mixer; only bumped ones still update speed and heading.
// Reset: aresetn clears speed, heading and bumper mask, empties the pipeline
//   and loads the register defaults (steps 10, limits -100/100).
// Backpressure: with m_tready low the result holds and each stage fills in
//   turn; s_tready drops only once all four stages hold results.
module differential_drive_servo_mixer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // opcode, value, bump_mask
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // left_angle, right_angle, left_speed, right_speed
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  ddsm_pkg::cfg_idx_t  cfg_index,
    input  logic [7:0]          cfg_data
);
    import ddsm_pkg::*;

    logic [6:0]        turn_delta_reg;
    logic [6:0]        speed_delta_reg;
    logic signed [7:0] left_limit_reg;
    logic [6:0]        right_limit_reg;
    logic signed [7:0] speed_floor_reg;
    logic [6:0]        speed_ceiling_reg;

    limits_t limits;
    logic    cmd_valid, cmd_ready;
    drive_t  cmd_drive;
    logic [7:0] left_angle, right_angle, left_speed, right_speed;

    // Register writes take effect at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_delta_reg    <= 7'd10;
            speed_delta_reg   <= 7'd10;
            left_limit_reg    <= -8'sd100;
            right_limit_reg   <= 7'd100;
            speed_floor_reg   <= -8'sd100;
            speed_ceiling_reg <= 7'd100;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TURN_DELTA:    turn_delta_reg    <= cfg_data[6:0];
                CFG_SPEED_DELTA:   speed_delta_reg   <= cfg_data[6:0];
                CFG_LEFT_LIMIT:    left_limit_reg    <= cfg_data;
                CFG_RIGHT_LIMIT:   right_limit_reg   <= cfg_data[6:0];
                CFG_SPEED_FLOOR:   speed_floor_reg   <= cfg_data;
                CFG_SPEED_CEILING: speed_ceiling_reg <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Saturate the limits so heading and speed stay in -100..100.
    always_comb begin
        limits.turn_delta  = turn_delta_reg;
        limits.speed_delta = speed_delta_reg;
        if (left_limit_reg > 8'sd0) begin
            limits.dir_lo = 8'sd0;
        end else if (left_limit_reg < FULL_NEG) begin
            limits.dir_lo = FULL_NEG;
        end else begin
            limits.dir_lo = left_limit_reg;
        end
        limits.dir_hi = (right_limit_reg > 7'd100) ? FULL_POS : {1'b0, right_limit_reg};
        if (speed_floor_reg > 8'sd0) begin
            limits.spd_lo = 8'sd0;
        end else if (speed_floor_reg < FULL_NEG) begin
            limits.spd_lo = FULL_NEG;
        end else begin
            limits.spd_lo = speed_floor_reg;
        end
        limits.spd_hi = (speed_ceiling_reg > 7'd100) ? FULL_POS : {1'b0, speed_ceiling_reg};
    end

    ddsm_cmd u_cmd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .limits    (limits),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (s_tdata[3:0]),
        .value     (s_tdata[11:4]),
        .bump_mask (s_tdata[19:12]),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_drive (cmd_drive)
    );

    ddsm_mix u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (cmd_valid),
        .in_ready    (cmd_ready),
        .in_drive    (cmd_drive),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .left_angle  (left_angle),
        .right_angle (right_angle),
        .left_speed  (left_speed),
        .right_speed (right_speed)
    );

    assign m_tdata = {right_speed, left_speed, right_angle, left_angle};

endmodule

// ===== rtl/core/ddsm_cmd.sv =====
// Command decode, drive state and the first pipeline register.
module ddsm_cmd (
    input  logic              aclk,
    input  logic              aresetn,
    input  ddsm_pkg::limits_t limits,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        opcode,
    input  logic [7:0]        value,
    input  logic [7:0]        bump_mask,
    output logic              out_valid,
    input  logic              out_ready,
    output ddsm_pkg::drive_t  out_drive
);
    import ddsm_pkg::*;

    logic signed [7:0] speed_reg, speed_next;
    logic signed [7:0] heading_reg, heading_next;
    logic [7:0]        bumper_reg, bumper_next;
    logic              valid_reg;
    drive_t            drive_reg;

    logic              accept;
    logic              emit;
    logic              bump_out;
    logic signed [7:0] val;
    logic signed [9:0] hdg_dec, hdg_inc, spd_inc, spd_dec;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign val      = value;

    assign hdg_dec = $signed({{2{heading_reg[7]}}, heading_reg})
                   - $signed({3'b000, limits.turn_delta});
    assign hdg_inc = $signed({{2{heading_reg[7]}}, heading_reg})
                   + $signed({3'b000, limits.turn_delta});
    assign spd_inc = $signed({{2{speed_reg[7]}}, speed_reg})
                   + $signed({3'b000, limits.speed_delta});
    assign spd_dec = $signed({{2{speed_reg[7]}}, speed_reg})
                   - $signed({3'b000, limits.speed_delta});

    always_comb begin
        speed_next   = speed_reg;
        heading_next = heading_reg;
        bumper_next  = bumper_reg;
        emit         = (bumper_reg == 8'd0);
        bump_out     = 1'b0;
        case (opcode)
            OP_FORWARD: begin
                speed_next   = FULL_POS;
                heading_next = 8'sd0;
            end
            OP_REVERSE: begin
                speed_next   = FULL_NEG;
                heading_next = 8'sd0;
            end
            OP_STOP: begin
                speed_next = 8'sd0;
            end
            OP_TURN_LEFT: begin
                heading_next = (hdg_dec < 10'(limits.dir_lo)) ? limits.dir_lo : hdg_dec[7:0];
            end
            OP_TURN_RIGHT: begin
                heading_next = (hdg_inc > 10'(limits.dir_hi)) ? limits.dir_hi : hdg_inc[7:0];
            end
            OP_SET_DIR: begin
                if (val < limits.dir_lo || val > limits.dir_hi) begin
                    emit = 1'b0;
                end else begin
                    heading_next = val;
                end
            end
            OP_SPEED_UP: begin
                speed_next = (spd_inc > 10'(limits.spd_hi)) ? limits.spd_hi : spd_inc[7:0];
            end
            OP_SLOW_DOWN: begin
                speed_next = (spd_dec < 10'(limits.spd_lo)) ? limits.spd_lo : spd_dec[7:0];
            end
            OP_SET_SPEED: begin
                if (val > FULL_POS) begin
                    speed_next = FULL_POS;
                end else if (val < FULL_NEG) begin
                    speed_next = FULL_NEG;
                end else begin
                    speed_next = val;
                end
            end
            OP_BUMP: begin
                bumper_next = bump_mask;
                emit        = 1'b1;
                bump_out    = (bump_mask != 8'd0);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg   <= 8'sd0;
            heading_reg <= 8'sd0;
            bumper_reg  <= 8'd0;
            valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                speed_reg   <= speed_next;
                heading_reg <= heading_next;
                bumper_reg  <= bumper_next;
                valid_reg   <= emit;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // A zero speed mixes to 90/90 with both wheel speeds zero.
    always_ff @(posedge aclk) begin
        if (accept) begin
            drive_reg.speed   <= bump_out ? 8'sd0 : speed_next;
            drive_reg.heading <= heading_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_drive = drive_reg;

endmodule

// ===== rtl/core/ddsm_mix.sv =====
// Three stage wheel mixer: products, divide by 100, servo angles.
module ddsm_mix (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  ddsm_pkg::drive_t in_drive,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       left_angle,
    output logic [7:0]       right_angle,
    output logic [7:0]       left_speed,
    output logic [7:0]       right_speed
);
    import ddsm_pkg::*;

    logic              prod_valid_reg, quot_valid_reg, out_valid_reg;
    logic signed [15:0] lprod_reg, rprod_reg;
    logic signed [7:0]  ls_reg, rs_reg;
    logic [7:0]         la_out_reg, ra_out_reg, ls_out_reg, rs_out_reg;

    logic              rdy_quot, rdy_out;
    logic signed [7:0] spd_in, hdg_in;
    logic signed [8:0] twice, lrel, rrel;
    logic signed [15:0] lprod, rprod;

    assign rdy_out  = !out_valid_reg || out_ready;
    assign rdy_quot = !quot_valid_reg || rdy_out;
    assign in_ready = !prod_valid_reg || rdy_quot;

    assign spd_in = in_drive.speed;
    assign hdg_in = in_drive.heading;
    assign twice  = {hdg_in, 1'b0};
    assign lrel   = hdg_in[7] ? 9'sd100 + twice : 9'sd100;
    assign rrel   = hdg_in[7] ? 9'sd100 : 9'sd100 - twice;
    assign lprod  = 16'(spd_in) * 16'(lrel);
    assign rprod  = 16'(spd_in) * 16'(rrel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            quot_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (rdy_quot) begin
                quot_valid_reg <= prod_valid_reg;
            end
            if (rdy_out) begin
                out_valid_reg <= quot_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            lprod_reg <= lprod;
            rprod_reg <= rprod;
        end
        if (rdy_quot) begin
            ls_reg <= trunc_div100(lprod_reg);
            rs_reg <= trunc_div100(rprod_reg);
        end
        if (rdy_out) begin
            la_out_reg <= servo_angle(8'd100 - ls_reg);
            ra_out_reg <= servo_angle(rs_reg + 8'd100);
            ls_out_reg <= ls_reg;
            rs_out_reg <= rs_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_angle  = la_out_reg;
    assign right_angle = ra_out_reg;
    assign left_speed  = ls_out_reg;
    assign right_speed = rs_out_reg;

endmodule

// ===== rtl/core/ddsm_checker.sv =====
// Port-level checks of the mixer, bound to its top level.
`include "differential_drive_servo_mixer_unit_macros.svh"

module ddsm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `DDSM_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (s_tready && !m_tvalid), "pipeline not empty after reset")
    `DDSM_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result changed while stalled")
    `DDSM_ASSERT(a_angle_range, m_tvalid |-> ((m_tdata[7:0] <= 8'd180) && (m_tdata[15:8] <= 8'd180)), "servo angle above 180")
    `DDSM_ASSERT(a_left_still, (m_tvalid && (m_tdata[23:16] == 8'd0)) |-> (m_tdata[7:0] == 8'd90), "left wheel stopped but angle not 90")
    `DDSM_ASSERT(a_right_still, (m_tvalid && (m_tdata[31:24] == 8'd0)) |-> (m_tdata[15:8] == 8'd90), "right wheel stopped but angle not 90")

endmodule

bind differential_drive_servo_mixer_unit ddsm_checker u_ddsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
